### rtl/sled_pkg.sv
`timescale 1ns / 1ps

package sled_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_HUNT     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN_LO   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_END = 3'd4;
    localparam logic [PHASE_W-1:0] PH_REPLAY   = 3'd5;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE   = 2'd1;

    localparam logic [7:0] START_BYTE_RESET = 8'h02;
    localparam logic [7:0] END_BYTE_RESET   = 8'h03;

    typedef logic [7:0] byte_t;

endpackage

### rtl/stx_length_etx_deframer.sv
`timescale 1ns / 1ps

// STX / length / ETX packet deframer.
// Input channel: rx_valid / rx_ready / rx_byte, one received byte per beat.
// The block hunts for the start byte, takes a 16-bit little-endian length,
// stores up to BUFFER_DEPTH payload bytes in a 64 x 8 synchronous RAM and then
// waits for the end byte. Bytes beyond the buffer are counted but dropped.
// Output channel: payload_valid / payload_ready with payload_byte, last_byte
// and truncated; one beat per stored payload byte, last_byte on the final one.
// Outside a replay every byte is accepted when offered. An end byte after a
// non-zero length starts a replay: a RAM read fills the read-data stage, then
// the output register presents the first beat. With payload_ready high the
// replay gives one beat per cycle, set by the single RAM read port and a
// one-beat read-data stage feeding the output register. rx_ready is low while
// replay reads are being issued. If the receiver stalls, the read-data stage
// and output register hold their beats and the replay pauses; nothing is lost.
// Reset returns the block to the hunt, restores the start and end bytes to
// their defaults and empties the output; the RAM needs no clearing pass.
// Configuration writes take effect for bytes accepted after the write edge.

module stx_length_etx_deframer
    import sled_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   rx_valid,
    output logic                   rx_ready,
    input  logic [7:0]             rx_byte,
    output logic                   payload_valid,
    input  logic                   payload_ready,
    output logic [7:0]             payload_byte,
    output logic                   last_byte,
    output logic                   truncated
);

    byte_t               start_byte_reg;
    byte_t               end_byte_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [15:0]         declared_length_reg;
    logic [15:0]         declared_length_next;
    logic [15:0]         received_count_reg;
    logic [15:0]         received_count_next;
    logic [LEN_W-1:0]    rep_len_reg;
    logic [LEN_W-1:0]    rep_len_next;
    logic [LEN_W-1:0]    rd_idx_reg;
    logic [LEN_W-1:0]    rd_idx_next;
    logic                trunc_reg;
    logic                trunc_next;

    byte_t               mem [BUFFER_DEPTH];
    byte_t               rd_data_reg;
    logic                rd_valid_reg;
    logic                rd_last_reg;
    logic                rd_trunc_reg;

    byte_t               out_byte_reg;
    logic                out_valid_reg;
    logic                out_last_reg;
    logic                out_trunc_reg;

    logic                rx_fire;
    logic                mem_we;
    logic                rd_en;
    logic                rd_last;
    logic                load_out;
    logic                is_end;
    logic [15:0]         count_inc;

    assign rx_ready  = (phase_reg != PH_REPLAY);
    assign rx_fire   = rx_valid && rx_ready;
    assign is_end    = (rx_byte == end_byte_reg);
    assign count_inc = received_count_reg + 16'd1;
    assign mem_we    = rx_fire && (phase_reg == PH_DATA)
                       && (received_count_reg < 16'(BUFFER_DEPTH));

    assign load_out  = rd_valid_reg && (!out_valid_reg || payload_ready);
    assign rd_en     = (phase_reg == PH_REPLAY) && (rd_idx_reg < rep_len_reg)
                       && (!rd_valid_reg || load_out);
    assign rd_last   = ((rd_idx_reg + LEN_W'(1)) == rep_len_reg);

    always_comb
    begin
        phase_next           = phase_reg;
        declared_length_next = declared_length_reg;
        received_count_next  = received_count_reg;
        rep_len_next         = rep_len_reg;
        rd_idx_next          = rd_idx_reg;
        trunc_next           = trunc_reg;
        if (phase_reg == PH_REPLAY)
        begin
            if (rd_en)
            begin
                rd_idx_next = rd_idx_reg + LEN_W'(1);
                if (rd_last)
                begin
                    phase_next = PH_HUNT;
                end
            end
        end
        else if (rx_fire)
        begin
            case (phase_reg)
                PH_LEN_LO:
                begin
                    declared_length_next = {8'd0, rx_byte};
                    phase_next           = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    declared_length_next = {rx_byte, declared_length_reg[7:0]};
                    phase_next = ({rx_byte, declared_length_reg[7:0]} != 16'd0)
                                 ? PH_DATA : PH_WAIT_END;
                end
                PH_DATA:
                begin
                    received_count_next = count_inc;
                    if (count_inc == declared_length_reg)
                    begin
                        phase_next = PH_WAIT_END;
                    end
                end
                PH_WAIT_END:
                begin
                    if (is_end)
                    begin
                        rd_idx_next = '0;
                        if (declared_length_reg > 16'(BUFFER_DEPTH))
                        begin
                            trunc_next   = 1'b1;
                            rep_len_next = LEN_W'(BUFFER_DEPTH);
                        end
                        else
                        begin
                            trunc_next   = 1'b0;
                            rep_len_next = declared_length_reg[LEN_W-1:0];
                        end
                        phase_next = (declared_length_reg != 16'd0) ? PH_REPLAY
                                                                    : PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte == start_byte_reg)
                    begin
                        phase_next           = PH_LEN_LO;
                        declared_length_next = 16'd0;
                        received_count_next  = 16'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg      <= START_BYTE_RESET;
            end_byte_reg        <= END_BYTE_RESET;
            phase_reg           <= PH_HUNT;
            declared_length_reg <= 16'd0;
            received_count_reg  <= 16'd0;
            rep_len_reg         <= '0;
            rd_idx_reg          <= '0;
            trunc_reg           <= 1'b0;
            rd_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_BYTE: start_byte_reg <= cfg_data;
                    REG_END_BYTE:   end_byte_reg   <= cfg_data;
                    default:        ;
                endcase
            end
            phase_reg           <= phase_next;
            declared_length_reg <= declared_length_next;
            received_count_reg  <= received_count_next;
            rep_len_reg         <= rep_len_next;
            rd_idx_reg          <= rd_idx_next;
            trunc_reg           <= trunc_next;
            if (rd_en)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (load_out)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (payload_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[received_count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_idx_reg[ADDR_W-1:0]];
            rd_last_reg  <= rd_last;
            rd_trunc_reg <= trunc_reg;
        end
        if (load_out)
        begin
            out_byte_reg  <= rd_data_reg;
            out_last_reg  <= rd_last_reg;
            out_trunc_reg <= rd_trunc_reg;
        end
    end

    assign payload_valid = out_valid_reg;
    assign payload_byte  = out_byte_reg;
    assign last_byte     = out_last_reg;
    assign truncated     = out_trunc_reg;

    // A read must never overwrite a read-data beat that has not moved on.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (!rd_valid_reg || load_out))
        else $error("read issued over a held read-data beat");

    // Replay only starts after an end byte accepted while waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(phase_reg == PH_REPLAY) |->
            $past(rx_fire && is_end && (phase_reg == PH_WAIT_END)))
        else $error("replay started without an end byte");

    // Reads stay within the stored part of the packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (rd_idx_reg < LEN_W'(BUFFER_DEPTH)) && (rep_len_reg != '0))
        else $error("replay read outside the stored payload");

endmodule
